>>> hw/rtl/dri_pkg.sv
package dri_pkg;

	// Sizes
	localparam int SLOTS_DEF = 64;
	localparam int KIND_W    = 3;
	localparam int SLOT_W    = 6;
	localparam int HANDLE_W  = 16;
	localparam int STAT_W    = 2;

	// Command kinds
	localparam logic [KIND_W-1:0] KIND_PUSH       = 3'd0;
	localparam logic [KIND_W-1:0] KIND_POP        = 3'd1;
	localparam logic [KIND_W-1:0] KIND_RELEASE    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CLOSE_SLOT = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLOSE_HNDL = 3'd4;
	localparam logic [KIND_W-1:0] KIND_SWEEP      = 3'd5;
	localparam logic [KIND_W-1:0] KIND_OPEN       = 3'd6;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;

	// Input beat
	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [SLOT_W-1:0]   slot;
		logic [HANDLE_W-1:0] handle;
	} item_t;

	// Result beat
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] slot_out;
		logic              last;
	} result_t;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SRCH,
		S_SWEEP
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic srch_step;
		logic sweep_step;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              any_close;
		logic              srch_done;
		logic              sweep_done;
	} stat_t;

endpackage

>>> hw/rtl/dri_ram.sv
module dri_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hw/rtl/dri_ctrl.sv
module dri_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  dri_pkg::stat_t stat,
	output logic           busy,
	output dri_pkg::cmd_t  cmd
);

	dri_pkg::state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dri_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			dri_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = dri_pkg::S_EXEC;
				end
			end
			dri_pkg::S_EXEC: begin
				if (stat.kind == dri_pkg::KIND_CLOSE_HNDL) begin
					cmd.srch_step = 1'b1;
					state_d       = dri_pkg::S_SRCH;
				end else if (stat.kind == dri_pkg::KIND_SWEEP && stat.any_close) begin
					cmd.sweep_step = 1'b1;
					state_d        = stat.sweep_done ? dri_pkg::S_IDLE : dri_pkg::S_SWEEP;
				end else begin
					cmd.exec = 1'b1;
					state_d  = dri_pkg::S_IDLE;
				end
			end
			dri_pkg::S_SRCH: begin
				cmd.srch_step = 1'b1;
				if (stat.srch_done) begin
					state_d = dri_pkg::S_IDLE;
				end
			end
			dri_pkg::S_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (stat.sweep_done) begin
					state_d = dri_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = dri_pkg::S_IDLE;
			end
		endcase
	end

endmodule

>>> hw/rtl/dri_dp.sv
module dri_dp #(
	parameter int SLOTS = dri_pkg::SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dri_pkg::cmd_t    cmd,
	input  dri_pkg::item_t   item,
	output dri_pkg::stat_t   stat,
	output dri_pkg::result_t result,
	output logic             strobe
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	dri_pkg::item_t   item_q;
	dri_pkg::result_t res_q, res_d;
	logic             strobe_q, strobe_d;

	logic [IW-1:0]    head_q, tail_q;
	logic [CW-1:0]    fill_q;
	logic [SLOTS-1:0] queued_q, close_q, open_q;

	logic [IW-1:0]    srch_cnt_q;
	logic             srch_more_q;
	logic             vld_s1;
	logic [IW-1:0]    idx_s1;
	logic [IW-1:0]    sw_q;

	logic [dri_pkg::SLOT_W-1:0]   ring_rdata;
	logic [dri_pkg::HANDLE_W-1:0] hnd_rdata;

	logic             in_range;
	logic [IW-1:0]    slot_i;
	logic             push_ok;
	logic             ring_we, hnd_we;
	logic             srch_hit, srch_done;
	logic             sw_flag, sweep_done;
	logic [SLOTS-1:0] close_rest;

	// Decode of the held item
	assign in_range = {1'b0, item_q.slot} < (dri_pkg::SLOT_W + 1)'(SLOTS);
	assign slot_i   = item_q.slot[IW-1:0];
	assign push_ok  = in_range && !queued_q[slot_i] && !close_q[slot_i]
		&& (fill_q < CW'(SLOTS));
	assign ring_we  = cmd.exec && (item_q.kind == dri_pkg::KIND_PUSH) && push_ok;
	assign hnd_we   = cmd.exec && (item_q.kind == dri_pkg::KIND_OPEN) && in_range;

	// FIFO storage, read port parked on the head
	dri_ram #(
		.WIDTH(dri_pkg::SLOT_W),
		.DEPTH(SLOTS)
	) u_ring (
		.clk  (clk),
		.we   (ring_we),
		.waddr(tail_q),
		.wdata(item_q.slot),
		.raddr(head_q),
		.rdata(ring_rdata)
	);

	// Handle per slot, read port follows the search counter
	dri_ram #(
		.WIDTH(dri_pkg::HANDLE_W),
		.DEPTH(SLOTS)
	) u_handle (
		.clk  (clk),
		.we   (hnd_we),
		.waddr(slot_i),
		.wdata(item_q.handle),
		.raddr(srch_cnt_q),
		.rdata(hnd_rdata)
	);

	// Search compare on the registered read
	assign srch_hit  = vld_s1 && open_q[idx_s1] && (hnd_rdata == item_q.handle);
	assign srch_done = vld_s1 && (srch_hit || (idx_s1 == IW'(SLOTS - 1)));

	// Sweep: last when no flag remains past the current slot
	assign sw_flag    = close_q[sw_q];
	assign close_rest = close_q & ~(SLOTS'(1) << sw_q);
	assign sweep_done = sw_flag && (close_rest == '0);

	assign stat.kind       = item_q.kind;
	assign stat.any_close  = |close_q;
	assign stat.srch_done  = srch_done;
	assign stat.sweep_done = sweep_done;

	// Result beat
	always_comb begin
		res_d.status   = dri_pkg::STAT_IGNORED;
		res_d.slot_out = '0;
		res_d.last     = 1'b1;
		strobe_d       = 1'b0;
		if (cmd.exec) begin
			strobe_d = 1'b1;
			case (item_q.kind)
				dri_pkg::KIND_PUSH: begin
					if (push_ok) res_d.status = dri_pkg::STAT_DONE;
				end
				dri_pkg::KIND_POP: begin
					if (fill_q == '0) begin
						res_d.status = dri_pkg::STAT_EMPTY;
					end else begin
						res_d.status   = dri_pkg::STAT_DONE;
						res_d.slot_out = ring_rdata;
					end
				end
				dri_pkg::KIND_RELEASE: begin
					if (in_range) res_d.status = dri_pkg::STAT_DONE;
				end
				dri_pkg::KIND_CLOSE_SLOT: begin
					if (in_range && open_q[slot_i]) res_d.status = dri_pkg::STAT_DONE;
				end
				dri_pkg::KIND_OPEN: begin
					if (in_range) res_d.status = dri_pkg::STAT_DONE;
				end
				default: begin
					res_d.status = dri_pkg::STAT_IGNORED;
				end
			endcase
		end
		if (cmd.srch_step && srch_done) begin
			strobe_d     = 1'b1;
			res_d.status = srch_hit ? dri_pkg::STAT_DONE : dri_pkg::STAT_IGNORED;
		end
		if (cmd.sweep_step && sw_flag) begin
			strobe_d       = 1'b1;
			res_d.status   = dri_pkg::STAT_DONE;
			res_d.slot_out = dri_pkg::SLOT_W'(sw_q);
			res_d.last     = sweep_done;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		res_q <= res_d;
	end

	// Control state and marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q    <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			fill_q      <= '0;
			queued_q    <= '0;
			close_q     <= '0;
			open_q      <= '0;
			srch_cnt_q  <= '0;
			srch_more_q <= 1'b0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			sw_q        <= '0;
		end else begin
			strobe_q <= strobe_d;

			// Walkers restart with every new item
			if (cmd.load) begin
				srch_cnt_q  <= '0;
				srch_more_q <= 1'b1;
				vld_s1      <= 1'b0;
				sw_q        <= '0;
			end

			// Single-beat kinds
			if (cmd.exec) begin
				case (item_q.kind)
					dri_pkg::KIND_PUSH: begin
						if (push_ok) begin
							queued_q[slot_i] <= 1'b1;
							tail_q <= (tail_q == IW'(SLOTS - 1)) ? '0 : tail_q + 1'b1;
							fill_q <= fill_q + 1'b1;
						end
					end
					dri_pkg::KIND_POP: begin
						if (fill_q != '0) begin
							head_q <= (head_q == IW'(SLOTS - 1)) ? '0 : head_q + 1'b1;
							fill_q <= fill_q - 1'b1;
						end
					end
					dri_pkg::KIND_RELEASE: begin
						if (in_range) queued_q[slot_i] <= 1'b0;
					end
					dri_pkg::KIND_CLOSE_SLOT: begin
						if (in_range && open_q[slot_i]) close_q[slot_i] <= 1'b1;
					end
					dri_pkg::KIND_OPEN: begin
						if (in_range) open_q[slot_i] <= 1'b1;
					end
					default: begin
					end
				endcase
			end

			// Handle search: issue one read a cycle, compare it in the cycle after
			if (cmd.srch_step) begin
				vld_s1 <= srch_more_q;
				idx_s1 <= srch_cnt_q;
				if (srch_more_q) begin
					if (srch_cnt_q == IW'(SLOTS - 1)) begin
						srch_more_q <= 1'b0;
					end else begin
						srch_cnt_q <= srch_cnt_q + 1'b1;
					end
				end
				if (srch_hit) begin
					close_q[idx_s1] <= 1'b1;
				end
			end

			// Sweep walk, one slot a cycle
			if (cmd.sweep_step) begin
				if (sw_flag) begin
					close_q[sw_q] <= 1'b0;
					open_q[sw_q]  <= 1'b0;
				end
				sw_q <= (sw_q == IW'(SLOTS - 1)) ? '0 : sw_q + 1'b1;
			end
		end
	end

	assign result = res_q;
	assign strobe = strobe_q;

endmodule

>>> hw/rtl/dedup_ready_index_queue_top.sv
// Ready-slot queue with pending marks for a table of SLOTS connection slots.
// Input channel: an item (kind, slot, handle) is taken at a rising edge with
// start high and busy low. busy rises the cycle after and stays high until the
// item's work is finished.
// Result channel: every result beat is shown for one cycle with strobe high;
// the receiver takes it at the end of that cycle and cannot hold it off.
// last marks the final beat of an item.
// Close by handle walks the handle memory one slot a cycle through its
// registered read port. Sweep walks the close marks one slot a cycle up to
// the highest flagged slot, giving one beat per flagged slot; with nothing
// flagged it gives a single beat.
// Reset (arst_n low) clears the queue pointers, fill count and all open,
// close and queued marks at once; the block is ready in the first cycle after.
module dedup_ready_index_queue_top #(
	parameter int SLOTS = dri_pkg::SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  dri_pkg::item_t   item,
	output dri_pkg::result_t result,
	output logic             strobe
);

	dri_pkg::cmd_t  cmd;
	dri_pkg::stat_t stat;

	dri_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.busy  (busy),
		.cmd   (cmd)
	);

	dri_dp #(
		.SLOTS(SLOTS)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.item  (item),
		.stat  (stat),
		.result(result),
		.strobe(strobe)
	);

	// An accepted beat keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");

	// Only sweep gives beats that are not last, and those are always done
	a_mid_done: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |-> result.status == dri_pkg::STAT_DONE)
		else $error("non-final beat without done status");

	// Empty pop reports slot zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.status == dri_pkg::STAT_EMPTY |-> result.slot_out == '0)
		else $error("empty pop with nonzero slot");

	// At most one controller command at a time
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("overlapping controller commands");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import dri_pkg::*;

	localparam int SLOTS      = SLOTS_DEF;
	localparam int MAX_CYCLES = 600000;
	localparam int SETTLE     = SLOTS + 8;
	localparam int N_RANDOM   = 100;

	// kind code with no operation behind it
	localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	logic    busy;
	item_t   item   = '0;
	result_t result;
	logic    strobe;

	dedup_ready_index_queue_top #(
		.SLOTS(SLOTS)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.item  (item),
		.result(result),
		.strobe(strobe)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the slot table and ready queue
	logic [SLOT_W-1:0]   q_ring [SLOTS];
	logic [SLOT_W-1:0]   q_head;
	logic [SLOT_W-1:0]   q_tail;
	logic [6:0]          q_fill;
	logic [SLOTS-1:0]    m_queued;
	logic [SLOTS-1:0]    m_close;
	logic [SLOTS-1:0]    m_open;
	logic [HANDLE_W-1:0] m_handle [SLOTS];

	result_t pending_results[$];
	int      err_count = 0;
	int      cycles    = 0;
	bit      no_idle   = 1'b0;

	task automatic flag_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		err_count++;
	endtask

	function automatic result_t mk_result(input logic [STAT_W-1:0] st,
		input logic [SLOT_W-1:0] so, input logic lst);
		result_t r;
		r.status   = st;
		r.slot_out = so;
		r.last     = lst;
		return r;
	endfunction

	function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] p);
		return (p == SLOTS - 1) ? '0 : p + 1'b1;
	endfunction

	// Apply one accepted beat to the shadow state, queue up what the block owes
	task automatic model_item(input item_t it);
		int  s;
		bit  found;
		int  n;
		s     = it.slot;
		found = 1'b0;
		n     = 0;
		case (it.kind)
			KIND_PUSH: begin
				if (s >= SLOTS || m_queued[s] || m_close[s] || q_fill >= SLOTS) begin
					pending_results.push_back(mk_result(STAT_IGNORED, '0, 1'b1));
				end else begin
					m_queued[s]    = 1'b1;
					q_ring[q_tail] = it.slot;
					q_tail         = ring_next(q_tail);
					q_fill++;
					pending_results.push_back(mk_result(STAT_DONE, '0, 1'b1));
				end
			end
			KIND_POP: begin
				if (q_fill == 0) begin
					pending_results.push_back(mk_result(STAT_EMPTY, '0, 1'b1));
				end else begin
					pending_results.push_back(mk_result(STAT_DONE, q_ring[q_head], 1'b1));
					q_head = ring_next(q_head);
					q_fill--;
				end
			end
			KIND_RELEASE: begin
				if (s >= SLOTS) begin
					pending_results.push_back(mk_result(STAT_IGNORED, '0, 1'b1));
				end else begin
					m_queued[s] = 1'b0;
					pending_results.push_back(mk_result(STAT_DONE, '0, 1'b1));
				end
			end
			KIND_CLOSE_SLOT: begin
				if (s < SLOTS && m_open[s]) begin
					m_close[s] = 1'b1;
					pending_results.push_back(mk_result(STAT_DONE, '0, 1'b1));
				end else begin
					pending_results.push_back(mk_result(STAT_IGNORED, '0, 1'b1));
				end
			end
			KIND_CLOSE_HNDL: begin
				// only the lowest open slot holding the handle gets flagged
				for (int i = 0; i < SLOTS && !found; i++) begin
					if (m_open[i] && m_handle[i] == it.handle) begin
						m_close[i] = 1'b1;
						found      = 1'b1;
					end
				end
				pending_results.push_back(mk_result(found ? STAT_DONE : STAT_IGNORED,
					'0, 1'b1));
			end
			KIND_SWEEP: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (m_close[i]) begin
						m_close[i] = 1'b0;
						m_open[i]  = 1'b0;
						pending_results.push_back(mk_result(STAT_DONE, i[SLOT_W-1:0], 1'b0));
						n++;
					end
				end
				if (n == 0) begin
					pending_results.push_back(mk_result(STAT_IGNORED, '0, 1'b1));
				end else begin
					pending_results[pending_results.size() - 1].last = 1'b1;
				end
			end
			KIND_OPEN: begin
				if (s >= SLOTS) begin
					pending_results.push_back(mk_result(STAT_IGNORED, '0, 1'b1));
				end else begin
					m_handle[s] = it.handle;
					m_open[s]   = 1'b1;
					pending_results.push_back(mk_result(STAT_DONE, '0, 1'b1));
				end
			end
			default: begin
				pending_results.push_back(mk_result(STAT_IGNORED, '0, 1'b1));
			end
		endcase
	endtask

	// Send one beat: optional random gap, then hold start until the block takes it
	task automatic issue(input logic [KIND_W-1:0] k, input logic [SLOT_W-1:0] s,
		input logic [HANDLE_W-1:0] h);
		item_t it;
		int    gap;
		it.kind   = k;
		it.slot   = s;
		it.handle = h;
		if (!no_idle && $urandom_range(0, 99) < 20) begin
			gap   = $urandom_range(1, 4);
			start <= 1'b0;
			item  <= item_t'($urandom);
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
		model_item(it);
	endtask

	// Hold off the sender until every owed result has shown up
	task automatic drain();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Result checker and watchdog
	always @(posedge clk) begin
		result_t want;
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("tb: errors");
			$finish;
		end
		if (arst_n && strobe) begin
			if (pending_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected result %p", result));
			end else begin
				want = pending_results.pop_front();
				if (result.status !== want.status)
					flag_mismatch($sformatf("status %0d, want %0d", result.status,
						want.status));
				if (result.slot_out !== want.slot_out)
					flag_mismatch($sformatf("slot_out %0d, want %0d", result.slot_out,
						want.slot_out));
				if (result.last !== want.last)
					flag_mismatch($sformatf("last %0b, want %0b", result.last, want.last));
			end
		end
	end

	// Every kind once plus the corner cases of each
	task automatic test_directed();
		issue(KIND_POP, 6'd0, 16'h0000);         // pop on empty queue
		issue(KIND_PUSH, 6'd0, 16'h0000);
		issue(KIND_PUSH, 6'd0, 16'hFFFF);        // already queued
		issue(KIND_PUSH, 6'd63, 16'h0000);
		issue(KIND_POP, 6'd63, 16'h0000);
		issue(KIND_POP, 6'd0, 16'h0000);
		issue(KIND_POP, 6'd0, 16'h0000);
		issue(KIND_RELEASE, 6'd0, 16'h0000);
		issue(KIND_PUSH, 6'd0, 16'h0000);        // queueable again after release
		issue(KIND_OPEN, 6'd3, 16'hFFFF);
		issue(KIND_OPEN, 6'd7, 16'hFFFF);
		issue(KIND_CLOSE_HNDL, 6'd0, 16'hFFFF);  // two matches, lowest wins
		issue(KIND_CLOSE_HNDL, 6'd0, 16'h1234);  // no match
		issue(KIND_CLOSE_SLOT, 6'd7, 16'h0000);
		issue(KIND_CLOSE_SLOT, 6'd10, 16'h0000); // slot never opened
		issue(KIND_PUSH, 6'd7, 16'h0000);        // close pending, refused
		issue(KIND_SWEEP, 6'd0, 16'h0000);
		issue(KIND_SWEEP, 6'd0, 16'h0000);       // nothing flagged
		issue(KIND_CLOSE_SLOT, 6'd3, 16'h0000);  // already closed
		issue(KIND_OPEN, 6'd3, 16'h0000);
		issue(KIND_OPEN, 6'd3, 16'h5555);        // overwrite handle of open slot
		issue(KIND_CLOSE_HNDL, 6'd0, 16'h0000);  // old handle is gone
		issue(KIND_UNUSED, 6'd63, 16'hFFFF);
		issue(KIND_RELEASE, 6'd63, 16'h0000);    // release of a popped slot that is still marked queued
		issue(KIND_OPEN, 6'd63, 16'h0000);
		issue(KIND_CLOSE_SLOT, 6'd63, 16'h0000);
		issue(KIND_SWEEP, 6'd0, 16'h0000);
	endtask

	// Fill the queue to SLOTS entries, then push a released but still queued slot
	task automatic test_queue_full();
		while (q_fill != 0) issue(KIND_POP, 6'd0, 16'h0000);
		for (int i = 0; i < SLOTS; i++)
			if (m_queued[i]) issue(KIND_RELEASE, i[SLOT_W-1:0], 16'h0000);
		if (m_close != '0) issue(KIND_SWEEP, 6'd0, 16'h0000);
		for (int i = 0; i < SLOTS; i++) issue(KIND_PUSH, i[SLOT_W-1:0], 16'h0000);
		issue(KIND_RELEASE, 6'd5, 16'h0000);
		issue(KIND_PUSH, 6'd5, 16'h0000);
		for (int i = 0; i <= SLOTS; i++) issue(KIND_POP, 6'd0, 16'h0000);
	endtask

	// Flag every slot and sweep them all in one go
	task automatic test_full_sweep();
		for (int i = 0; i < SLOTS; i++)
			issue(KIND_OPEN, i[SLOT_W-1:0], 16'($urandom));
		issue(KIND_CLOSE_HNDL, 6'd0, m_handle[0]);
		for (int i = 0; i < SLOTS; i++) issue(KIND_CLOSE_SLOT, i[SLOT_W-1:0], 16'h0000);
		issue(KIND_SWEEP, 6'd0, 16'h0000);
		for (int i = 0; i < SLOTS; i++) issue(KIND_RELEASE, i[SLOT_W-1:0], 16'h0000);
	endtask

	function automatic logic [SLOT_W-1:0] pick_slot();
		return ($urandom_range(0, 99) < 70) ? SLOT_W'($urandom_range(0, 7))
			: SLOT_W'($urandom_range(0, SLOTS - 1));
	endfunction

	function automatic logic [HANDLE_W-1:0] pick_handle();
		case ($urandom_range(0, 4))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'h00A5;
			default: return 16'($urandom);
		endcase
	endfunction

	// Random traffic weighted toward sequences that hit live slots
	task automatic test_random();
		int                  w;
		logic [SLOT_W-1:0]   s;
		logic [HANDLE_W-1:0] h;
		for (int i = 0; i < N_RANDOM; i++) begin
			no_idle = (i >= 30 && i < 80);
			w = $urandom_range(0, 99);
			s = pick_slot();
			h = pick_handle();
			if (w < 20) begin
				issue(KIND_PUSH, s, h);
			end else if (w < 40) begin
				issue(KIND_POP, s, h);
			end else if (w < 50) begin
				issue(KIND_RELEASE, s, h);
			end else if (w < 60) begin
				issue(KIND_CLOSE_SLOT, s, h);
			end else if (w < 70) begin
				// mostly a handle that some open slot holds
				if (m_open[s] && $urandom_range(0, 99) < 75) h = m_handle[s];
				issue(KIND_CLOSE_HNDL, s, h);
			end else if (w < 76) begin
				issue(KIND_SWEEP, s, h);
			end else if (w < 97) begin
				issue(KIND_OPEN, s, h);
			end else begin
				issue(KIND_UNUSED, s, h);
			end
			if (i % 50 == 49) drain();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		q_head   = '0;
		q_tail   = '0;
		q_fill   = '0;
		m_queued = '0;
		m_close  = '0;
		m_open   = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_queue_full();
		test_full_sweep();
		test_random();

		drain();
		repeat (SETTLE) @(posedge clk);
		if (err_count == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/dri_pkg.sv
hw/rtl/dri_ram.sv
hw/rtl/dri_ctrl.sv
hw/rtl/dri_dp.sv
hw/rtl/dedup_ready_index_queue_top.sv
tb/tb.sv
